// ===== hw/rtl/mlfs_pkg.sv =====
package mlfs_pkg;

  localparam int unsigned IdW    = 5;
  localparam int unsigned PrioW  = 4;
  localparam int unsigned TickW  = 20;
  localparam int unsigned QuantW = 16;
  localparam int unsigned NumIds = 32;

  // Priority numbers at or above this limit never beat the queue head.
  localparam logic [PrioW-1:0] PrioLimit = 4'd3;

  typedef enum logic [1:0] {
    FUNC_READY   = 2'd0,
    FUNC_PICK    = 2'd1,
    FUNC_PREEMPT = 2'd2,
    FUNC_EXPIRY  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_RR   = 2'd0,
    MODE_PRIO = 2'd1,
    MODE_MLFQ = 2'd2,
    MODE_ALT  = 2'd3
  } mode_t;

  typedef enum logic {
    REG_MODE    = 1'b0,
    REG_QUANTUM = 1'b1
  } reg_idx_t;

  // One queue slot as held in a cell.
  typedef struct packed {
    logic             vld;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } slot_t;

  // Command broadcast from the sequencer to every cell of a queue.
  typedef struct packed {
    logic             push;
    logic             shift;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/multilevel_feedback_scheduler_top.sv =====
// Thread scheduler with three order-keeping queues held in rows of cells
// (one cell per queue position) and a 32-entry level table. Ready, plain
// pick and the feedback queries need no walk. A priority pick or
// a priority preempt query walks the top queue one cell per cycle up
// to its first empty cell; a removal then shifts all later cells
// together. One item is in work at a time, and a finished
// result waits in the output register; the next item is taken only once
// that result leaves, at the earliest in the same cycle.
module multilevel_feedback_scheduler_top
  import mlfs_pkg::*;
#(
  parameter int unsigned MAX_THREADS = 32
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [QuantW-1:0]         cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                func,
  input  logic [IdW-1:0]            thread_id,
  input  logic [TickW-1:0]          ticks_used,
  input  logic [PrioW-1:0]          thread_priority,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IdW-1:0]            chosen_id,
  output logic                      found,
  output logic                      answer_flag,
  output logic                      overflow
);

  localparam int unsigned PosW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int unsigned CntW = $clog2(MAX_THREADS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;
  mode_t  sched_mode;
  logic [QuantW-1:0] base_quantum;
  logic [1:0] level_table [NumIds];

  // Latched item.
  func_t             f_q;
  logic [IdW-1:0]    id_q;
  logic [TickW-1:0]  ticks_q;
  logic [PrioW-1:0]  prio_q;

  // Scan state for priority walks.
  logic [CntW-1:0]   scan_i;
  logic [PrioW-1:0]  best;
  logic [PosW-1:0]   best_pos;
  logic              hit;

  cell_cmd_t cmd_top, cmd_mid, cmd_low;
  logic [PosW-1:0] pos_top;
  slot_t top_s [MAX_THREADS];
  slot_t mid_s [MAX_THREADS];
  slot_t low_s [MAX_THREADS];
  logic top_full, mid_full, low_full, top_empty, mid_empty, low_empty;

  mlfs_queue #(.Depth(MAX_THREADS)) u_top (
    .clk(clk), .rst(rst), .cmd(cmd_top), .pos(pos_top),
    .slots(top_s), .full(top_full), .empty(top_empty));
  mlfs_queue #(.Depth(MAX_THREADS)) u_mid (
    .clk(clk), .rst(rst), .cmd(cmd_mid), .pos('0),
    .slots(mid_s), .full(mid_full), .empty(mid_empty));
  mlfs_queue #(.Depth(MAX_THREADS)) u_low (
    .clk(clk), .rst(rst), .cmd(cmd_low), .pos('0),
    .slots(low_s), .full(low_full), .empty(low_empty));

  // Level of the latched thread and its quantum check.
  logic [1:0]        lvl;
  logic [TickW-1:0]  quantum;
  logic              expired;
  logic [1:0]        target;
  logic              tgt_full;
  slot_t             scan_slot;

  always_comb begin
    lvl = (level_table[id_q] == 2'd3) ? 2'd2 : level_table[id_q];
    quantum = TickW'(base_quantum);
    if (sched_mode == MODE_MLFQ) begin
      quantum = TickW'(base_quantum) << lvl;
    end
    expired = ticks_q > quantum;
    target = 2'd0;
    if (sched_mode == MODE_MLFQ) begin
      target = (expired && lvl < 2'd2) ? lvl + 2'd1 : lvl;
    end
    case (target)
      2'd0:    tgt_full = top_full;
      2'd1:    tgt_full = mid_full;
      default: tgt_full = low_full;
    endcase
    scan_slot = top_s[scan_i[PosW-1:0]];
  end

  assign cfg_ready = (state == ST_IDLE);
  assign in_ready  = (state == ST_IDLE) && (!out_valid || out_ready);

  // Queue commands, issued in the cycle the item completes.
  always_comb begin
    cmd_top = '0;
    cmd_mid = '0;
    cmd_low = '0;
    cmd_top.id = id_q; cmd_top.prio = prio_q;
    cmd_mid.id = id_q; cmd_mid.prio = prio_q;
    cmd_low.id = id_q; cmd_low.prio = prio_q;
    pos_top = '0;
    if (state == ST_DONE) begin
      case (f_q)
        FUNC_READY: begin
          if (!tgt_full) begin
            case (target)
              2'd0:    cmd_top.push = 1'b1;
              2'd1:    cmd_mid.push = 1'b1;
              default: cmd_low.push = 1'b1;
            endcase
          end
        end
        FUNC_PICK: begin
          if (sched_mode == MODE_PRIO) begin
            pos_top = best_pos;
            cmd_top.shift = !top_empty;
          end else if (sched_mode == MODE_MLFQ) begin
            if (!top_empty)      cmd_top.shift = 1'b1;
            else if (!mid_empty) cmd_mid.shift = 1'b1;
            else                 cmd_low.shift = !low_empty;
          end else begin
            cmd_top.shift = !top_empty;
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      sched_mode   <= MODE_RR;
      base_quantum <= QuantW'(100);
      for (int k = 0; k < NumIds; k++) level_table[k] <= 2'd0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == REG_MODE) sched_mode <= mode_t'(cfg_data[1:0]);
            else base_quantum <= cfg_data;
          end
          if (in_valid && in_ready) begin
            f_q      <= func_t'(func);
            id_q     <= thread_id;
            ticks_q  <= ticks_used;
            prio_q   <= thread_priority;
            scan_i   <= '0;
            best     <= PrioLimit;
            best_pos <= '0;
            hit      <= 1'b0;
            if (sched_mode == MODE_PRIO &&
                (func == FUNC_PICK || func == FUNC_PREEMPT)) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          // Walk the top queue one cell per cycle up to its first empty cell.
          if (scan_i == CntW'(MAX_THREADS) || !scan_slot.vld) begin
            state <= ST_DONE;
          end else begin
            if (scan_slot.prio < best) begin
              best     <= scan_slot.prio;
              best_pos <= scan_i[PosW-1:0];
            end
            if (prio_q > scan_slot.prio) hit <= 1'b1;
            scan_i <= scan_i + 1'b1;
          end
        end
        ST_DONE: begin
          state       <= ST_IDLE;
          out_valid   <= 1'b1;
          chosen_id   <= '0;
          found       <= 1'b0;
          answer_flag <= 1'b0;
          overflow    <= 1'b0;
          case (f_q)
            FUNC_READY: begin
              if (tgt_full) overflow <= 1'b1;
              else if (sched_mode == MODE_MLFQ) level_table[id_q] <= target;
            end
            FUNC_PICK: begin
              if (sched_mode == MODE_PRIO) begin
                if (!top_empty) begin
                  found <= 1'b1; chosen_id <= top_s[best_pos].id;
                end
              end else if (sched_mode == MODE_MLFQ) begin
                if (!top_empty) begin
                  found <= 1'b1; chosen_id <= top_s[0].id;
                end else if (!mid_empty) begin
                  found <= 1'b1; chosen_id <= mid_s[0].id;
                end else if (!low_empty) begin
                  found <= 1'b1; chosen_id <= low_s[0].id;
                end
              end else if (!top_empty) begin
                found <= 1'b1; chosen_id <= top_s[0].id;
              end
            end
            FUNC_PREEMPT: begin
              if (sched_mode == MODE_MLFQ) begin
                if (lvl == 2'd1) answer_flag <= !top_empty;
                else if (lvl == 2'd2) answer_flag <= !top_empty || !mid_empty;
              end else if (sched_mode == MODE_PRIO) begin
                answer_flag <= hit;
              end
            end
            default: answer_flag <= expired;
          endcase
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mlfs_cell.sv =====
// One queue position. A push lands in the first empty cell; a shift
// removes this cell's entry by taking the right neighbor's when take is set.
module mlfs_cell
  import mlfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  logic      prev_vld,
  input  logic      take,
  input  slot_t     right,
  output slot_t     slot
);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.vld <= 1'b0;
    end else if (cmd.shift && take) begin
      slot <= right;
    end else if (cmd.push && prev_vld && !slot.vld) begin
      slot.vld  <= 1'b1;
      slot.id   <= cmd.id;
      slot.prio <= cmd.prio;
    end
  end

endmodule

// ===== hw/rtl/mlfs_queue.sv =====
// An order-keeping queue as a row of cells. Removing position pos makes
// every cell at or after pos take its right neighbor together.
module mlfs_queue
  import mlfs_pkg::*;
#(
  parameter int unsigned Depth = 32,
  localparam int unsigned PosW = (Depth > 1) ? $clog2(Depth) : 1
)
(
  input  logic            clk,
  input  logic            rst,
  input  cell_cmd_t       cmd,
  input  logic [PosW-1:0] pos,
  output slot_t           slots [Depth],
  output logic            full,
  output logic            empty
);

  slot_t tail;

  assign tail  = '0;
  assign full  = slots[Depth-1].vld;
  assign empty = !slots[0].vld;

  for (genvar c = 0; c < Depth; c++) begin : g_cell
    logic  prev_vld;
    logic  take;
    slot_t right;
    slot_t slot_q;
    if (c == 0) begin : g_first
      assign prev_vld = 1'b1;
    end else begin : g_rest
      assign prev_vld = slots[c-1].vld;
    end
    if (c == Depth - 1) begin : g_last
      assign right = tail;
    end else begin : g_mid
      assign right = slots[c+1];
    end
    assign take = (PosW'(c) >= pos);
    mlfs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .prev_vld (prev_vld),
      .take     (take),
      .right    (right),
      .slot     (slot_q)
    );
    assign slots[c] = slot_q;
  end

endmodule

// ===== hw/rtl/mlfs_checker.sv =====
// Port-level checks on the scheduler.
module mlfs_checker
  import mlfs_pkg::*;
(
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input logic [IdW-1:0] chosen_id,
  input logic           found,
  input logic           answer_flag,
  input logic           overflow
);

  // A result never carries more than one kind of answer.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({found, answer_flag, overflow}) <= 1)
    else $error("result carries more than one answer");

  // A result without a find names no thread.
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> chosen_id == '0)
    else $error("chosen id set without a find");

  // An item beat is taken only when no result is left waiting.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("item taken while a result waits");

  // A stalled result stays valid and holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable({chosen_id, found, answer_flag, overflow}))
    else $error("stalled result changed");

endmodule

bind multilevel_feedback_scheduler_top mlfs_checker u_mlfs_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .chosen_id(chosen_id),
  .found(found), .answer_flag(answer_flag), .overflow(overflow));
